// ===== src/swtl_pkg.sv =====
// Shared types and constants for the sorted word table lookup block.
package swtl_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int WORD_CHARS_DEFAULT = 16;

   localparam int WORD_BITS     = 128;
   localparam int CATEGORY_BITS = 6;
   localparam int POS_W         = 11;
   localparam int ENABLE_BITS   = 64;

   // APB-style register port: one 64-bit register at byte address 0
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic CSR_IDX_CATEGORY_ENABLE = 1'b0;
   localparam logic [CSR_DATA_W-1:0] CATEGORY_ENABLE_RESET = 64'h1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_DONE      = 3'd0,
      STAT_MATCH     = 3'd1,
      STAT_DISABLED  = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_LOOKUP
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [63:0] word_high;
      logic [63:0] word_low;
      logic [5:0]  entry_category;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  position;
   } rsp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]     word;
      logic [CATEGORY_BITS-1:0] category;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== src/sorted_word_table_lookup.sv =====
// Top level: register port, sequencer and entry memory.
//
// Sorted word table with binary-search lookup.
// Input: an item is transferred when start is high and busy is low. The
// command clears the table, appends one word with its category at the end,
// or looks a word up. Words must be appended in ascending order.
// Output: every item gives exactly one result on rsp_item, shown for one
// cycle with rsp_strobe; the receiver always takes it.
// Clear and append never raise busy; their result appears in the cycle after
// the transfer, and a new item may be transferred in every cycle.
// A lookup raises busy and probes the entry memory once per cycle through
// its single read port: with N entries it takes up to floor(log2(N)) + 1
// probes, and busy drops in the cycle in which the result appears.
// Register port: category_enable (64 bits) at byte address 0, reset 1.
// Write it only while no lookup is in progress.
// Reset (synchronous) empties the table and restores category_enable;
// the entry memory itself is not cleared.
module sorted_word_table_lookup #(
   parameter int DEPTH      = swtl_pkg::DEPTH_DEFAULT,
   parameter int WORD_CHARS = swtl_pkg::WORD_CHARS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  swtl_pkg::req_type                   req_item,
   output logic                                rsp_strobe,
   output swtl_pkg::rsp_type                   rsp_item,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swtl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swtl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swtl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = $clog2(DEPTH);

   logic [swtl_pkg::CSR_DATA_W-1:0] category_enable_ff, category_enable_in;
   logic                            csr_hit;
   logic                            csr_write;

   swtl_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]         wr_addr;
   swtl_pkg::entry_type   wr_data;
   logic [AW-1:0]         rd_addr;
   swtl_pkg::entry_type   rd_data;

   // 8-byte register slots: bit 3 upward selects the register
   assign csr_hit   = csr_paddr[swtl_pkg::CSR_ADDR_W-1:3] == swtl_pkg::CSR_IDX_CATEGORY_ENABLE;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      category_enable_in = category_enable_ff;
      if (csr_write && csr_hit) begin
         category_enable_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         category_enable_ff <= swtl_pkg::CATEGORY_ENABLE_RESET;
      end else begin
         category_enable_ff <= category_enable_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? category_enable_ff : '0;

   swtl_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_CHARS (WORD_CHARS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_item        (req_item),
      .category_enable (category_enable_ff),
      .mem_ctl         (mem_ctl),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_item        (rsp_item)
   );

   swtl_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ===== src/swtl_store.sv =====
// Entry memory: one write port, one read port with registered read data.
module swtl_store #(
   parameter int DEPTH = swtl_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  swtl_pkg::mem_ctl_type    ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  swtl_pkg::entry_type      wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output swtl_pkg::entry_type      rd_data
);

   swtl_pkg::entry_type entry_mem [DEPTH];
   swtl_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/swtl_ctrl.sv =====
// Command sequencer: clear, append and one-probe-per-cycle binary search.
module swtl_ctrl #(
   parameter int DEPTH      = swtl_pkg::DEPTH_DEFAULT,
   parameter int WORD_CHARS = swtl_pkg::WORD_CHARS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  swtl_pkg::req_type                   req_item,
   input  logic [swtl_pkg::ENABLE_BITS-1:0]    category_enable,
   output swtl_pkg::mem_ctl_type               mem_ctl,
   output logic [$clog2(DEPTH)-1:0]            wr_addr,
   output swtl_pkg::entry_type                 wr_data,
   output logic [$clog2(DEPTH)-1:0]            rd_addr,
   input  swtl_pkg::entry_type                 rd_data,
   output logic                                rsp_strobe,
   output swtl_pkg::rsp_type                   rsp_item
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = swtl_pkg::POS_W;
   localparam int WB = swtl_pkg::WORD_BITS;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   // keep the first WORD_CHARS characters, zero the rest
   localparam logic [WB-1:0] KEY_MASK = ~({WB{1'b1}} >> (8 * WORD_CHARS));

   swtl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hx_ff, hx_in;   // exclusive upper bound
   logic [AW-1:0]       mid_ff, mid_in;
   logic                pend_ff, pend_in;
   logic [WB-1:0]       key_ff, key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   swtl_pkg::rsp_type   rsp_ff, rsp_in;

   logic [WB-1:0] key_masked;
   logic          stored_lt;
   logic          stored_eq;
   logic          hit;
   logic          cat_on;
   logic [CW-1:0] mid_ext;
   logic [CW-1:0] mid_plus1;
   logic          cond_lt;
   logic          cond_gt;
   logic [CW:0]   sum_init;
   logic [CW:0]   sum_lt;
   logic [CW:0]   sum_gt;
   logic          go_on;
   logic [CW-1:0] lo_next;
   logic [CW-1:0] hx_next;
   logic [AW-1:0] mid_next;
   logic          search_done;

   assign key_masked = {req_item.word_high, req_item.word_low} & KEY_MASK;

   assign stored_lt = rd_data.word < key_ff;
   assign stored_eq = rd_data.word == key_ff;
   assign hit       = pend_ff && stored_eq;
   assign cat_on    = category_enable[rd_data.category];

   // both candidate next probes are formed alongside the compare
   assign mid_ext   = CW'(mid_ff);
   assign mid_plus1 = mid_ext + CW'(1);
   assign cond_lt   = mid_plus1 < hx_ff;
   assign cond_gt   = lo_ff < mid_ext;
   assign sum_init  = (CW+1)'(lo_ff) + (CW+1)'(hx_ff) - (CW+1)'(1);
   assign sum_lt    = (CW+1)'(mid_ext) + (CW+1)'(hx_ff);
   assign sum_gt    = (CW+1)'(lo_ff) + (CW+1)'(mid_ext) - (CW+1)'(1);

   always_comb begin
      priority if (!pend_ff) begin
         go_on    = lo_ff < hx_ff;
         lo_next  = lo_ff;
         hx_next  = hx_ff;
         mid_next = sum_init[AW:1];
      end else if (stored_lt) begin
         go_on    = cond_lt;
         lo_next  = mid_plus1;
         hx_next  = hx_ff;
         mid_next = sum_lt[AW:1];
      end else begin
         go_on    = cond_gt;
         lo_next  = lo_ff;
         hx_next  = mid_ext;
         mid_next = sum_gt[AW:1];
      end
   end

   assign search_done = hit || !go_on;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swtl_pkg::FSM_IDLE: begin
            if (start && req_item.command == swtl_pkg::CMD_LOOKUP) begin
               state_in = swtl_pkg::FSM_LOOKUP;
            end
         end
         swtl_pkg::FSM_LOOKUP: begin
            if (search_done) begin
               state_in = swtl_pkg::FSM_IDLE;
            end
         end
         default: state_in = swtl_pkg::FSM_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_ctl      = '0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{word: key_masked, category: req_item.entry_category};
      rd_addr      = mid_next;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hx_in        = hx_ff;
      mid_in       = mid_ff;
      pend_in      = pend_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         swtl_pkg::FSM_IDLE: begin
            if (start) begin
               key_in       = key_masked;
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: swtl_pkg::STAT_DONE, position: '0};
               unique case (req_item.command)
                  swtl_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  swtl_pkg::CMD_APPEND: begin
                     rsp_in.position = PW'(count_ff);
                     if (count_ff == FULL_COUNT) begin
                        rsp_in.status = swtl_pkg::STAT_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  swtl_pkg::CMD_LOOKUP: begin
                     rsp_valid_in = 1'b0;
                     lo_in        = '0;
                     hx_in        = count_ff;
                     pend_in      = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         swtl_pkg::FSM_LOOKUP: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: cat_on ? swtl_pkg::STAT_MATCH : swtl_pkg::STAT_DISABLED,
                          position: PW'(mid_ff)};
               pend_in = 1'b0;
            end else if (go_on) begin
               mem_ctl.rd_en = 1'b1;
               mid_in        = mid_next;
               lo_in         = lo_next;
               hx_in         = hx_next;
               pend_in       = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: swtl_pkg::STAT_NOT_FOUND, position: PW'(lo_next)};
               pend_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swtl_pkg::FSM_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hx_ff  <= hx_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = state_ff != swtl_pkg::FSM_IDLE;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== src/swtl_checker.sv =====
// Port-level checks for the sorted word table lookup, bound to the top level.
module swtl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input swtl_pkg::req_type req_item,
   input logic              rsp_strobe,
   input swtl_pkg::rsp_type rsp_item
);

   // clear and append answer in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.command != swtl_pkg::CMD_LOOKUP |=> rsp_strobe)
      else $error("swtl: no result the cycle after a non-lookup transfer");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.command == swtl_pkg::CMD_LOOKUP |=> busy && !rsp_strobe)
      else $error("swtl: lookup transfer did not raise busy");

   // nothing else can produce a result while a search runs
   assert property (@(posedge clock) disable iff (reset)
      !(busy && rsp_strobe))
      else $error("swtl: result shown while busy");

   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |->
         rsp_strobe && (rsp_item.status == swtl_pkg::STAT_MATCH ||
                        rsp_item.status == swtl_pkg::STAT_DISABLED ||
                        rsp_item.status == swtl_pkg::STAT_NOT_FOUND))
      else $error("swtl: search ended without a lookup result");

endmodule

bind sorted_word_table_lookup swtl_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
